// File: rtl/dfzc_pkg.sv
// shared constants, types and coefficient table for the decimated fir zero crossing detector
`timescale 1ns / 1ps

package dfzc_pkg;

	localparam int FILTER_ORDER = 20;
	localparam int NUM_TAPS     = FILTER_ORDER + 1;
	localparam int SAMPLE_BITS  = 24;
	localparam int COEFF_BITS   = 18;

	localparam int TAP_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int BIT_W = $clog2(COEFF_BITS);
	localparam int ACC_W = SAMPLE_BITS + COEFF_BITS + TAP_W + 1;

	// decimation control
	localparam int DECIM_W     = 7;
	localparam int CNT_W       = 6;
	localparam int MAX_DECIM   = 64;
	localparam int DECIM_RESET = 10;

	// register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_DECIM = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILT,
		ST_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		MAC_IDLE,
		MAC_RUN,
		MAC_ROUND
	} mac_state_t;

	typedef struct packed {
		logic                          start;
		logic signed [SAMPLE_BITS-1:0] sample;
	} mac_req_t;

	typedef struct packed {
		logic                          done;
		logic signed [SAMPLE_BITS-1:0] y;
	} mac_rsp_t;

	// symmetric low-pass taps, unsigned q0.18, unity dc gain; taps beyond the table are zero
	function automatic logic [31:0] coeff_word(input logic [TAP_W-1:0] idx);
		logic [31:0] w;
		case (idx)
			0:       w = 32'd3457;
			1:       w = 32'd5248;
			2:       w = 32'd7258;
			3:       w = 32'd9405;
			4:       w = 32'd11589;
			5:       w = 32'd13701;
			6:       w = 32'd15626;
			7:       w = 32'd17256;
			8:       w = 32'd18495;
			9:       w = 32'd19270;
			10:      w = 32'd19534;
			11:      w = 32'd19270;
			12:      w = 32'd18495;
			13:      w = 32'd17256;
			14:      w = 32'd15626;
			15:      w = 32'd13701;
			16:      w = 32'd11589;
			17:      w = 32'd9405;
			18:      w = 32'd7258;
			19:      w = 32'd5248;
			20:      w = 32'd3457;
			default: w = 32'd0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/dfzc_cfg.sv
// apb register block holding the decimation factor
`timescale 1ns / 1ps

module dfzc_cfg import dfzc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output logic [DECIM_W-1:0] decim
);

	logic [DECIM_W-1:0] decim_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign decim  = decim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_W'(DECIM_RESET);
		end else if (wr_en && (paddr[ADDR_W-1] == REG_DECIM)) begin
			decim_q <= pwdata[DECIM_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1])
			REG_DECIM: prdata = DATA_W'(decim_q);
			default:   prdata = '0;
		endcase
	end

endmodule

// File: rtl/dfzc_mac.sv
// tap delay line and bit-serial multiply-accumulate with rounding and saturation
`timescale 1ns / 1ps

module dfzc_mac import dfzc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_req_t req,
	output mac_rsp_t rsp
);

	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COEFF_BITS - 1);
	localparam logic signed [ACC_W-1:0] ONE_A    = ACC_W'(1);
	localparam logic signed [ACC_W-1:0] HALF_LSB = ONE_A <<< (COEFF_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI   = (ONE_A <<< (SAMPLE_BITS - 1)) - ONE_A;
	localparam logic signed [ACC_W-1:0] SAT_LO   = -(ONE_A <<< (SAMPLE_BITS - 1));

	mac_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] taps_q [NUM_TAPS];
	logic [TAP_W-1:0]              tap_idx_q;
	logic [BIT_W-1:0]              bit_idx_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          done_q;
	logic signed [SAMPLE_BITS-1:0] y_q;

	logic [31:0]             coef_word;
	logic [COEFF_BITS-1:0]   coef;
	logic                    cbit;
	logic signed [ACC_W-1:0] term, base, acc_sum, rounded, shifted;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                    load, step, pass_end, finish;

	// one coefficient bit per cycle, msb first; the head tap rotates past once per bit
	always_comb begin
		coef_word = coeff_word(tap_idx_q);
		coef      = coef_word[COEFF_BITS-1:0];
		cbit      = coef[bit_idx_q];
		term      = cbit ? ACC_W'(taps_q[0]) : '0;
		base      = (tap_idx_q == '0) ? (acc_q <<< 1) : acc_q;
		acc_sum   = base + term;
		rounded   = acc_q + HALF_LSB;
		shifted   = rounded >>> COEFF_BITS;
		if (shifted > SAT_HI) begin
			y_sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_LO) begin
			y_sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			y_sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MAC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load     = 1'b0;
		step     = 1'b0;
		finish   = 1'b0;
		pass_end = (tap_idx_q == LAST_TAP);
		unique case (state_q)
			MAC_IDLE: begin
				if (req.start) begin
					load    = 1'b1;
					state_d = MAC_RUN;
				end
			end
			MAC_RUN: begin
				step = 1'b1;
				if (pass_end && (bit_idx_q == '0)) begin
					state_d = MAC_ROUND;
				end
			end
			MAC_ROUND: begin
				finish  = 1'b1;
				state_d = MAC_IDLE;
			end
			default: state_d = MAC_IDLE;
		endcase
	end

	// delay line: shifts in on a new sample, rotates during the passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				taps_q[i] <= '0;
			end
		end else if (load) begin
			taps_q[0] <= req.sample;
			for (int i = 1; i < NUM_TAPS; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end else if (step) begin
			for (int i = 0; i < NUM_TAPS - 1; i++) begin
				taps_q[i] <= taps_q[i+1];
			end
			taps_q[NUM_TAPS-1] <= taps_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_idx_q <= '0;
			bit_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= finish;
			if (load) begin
				tap_idx_q <= '0;
				bit_idx_q <= LAST_BIT;
			end else if (step) begin
				if (pass_end) begin
					tap_idx_q <= '0;
					bit_idx_q <= bit_idx_q - BIT_W'(1);
				end else begin
					tap_idx_q <= tap_idx_q + TAP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= '0;
		end else if (step) begin
			acc_q <= acc_sum;
		end
		if (finish) begin
			y_q <= y_sat;
		end
	end

	assign rsp.done = done_q;
	assign rsp.y    = y_q;

endmodule

// File: rtl/decimated_fir_zero_cross_detector_core.sv
// top level: sample decimation, filter control, crossing detection and result register
`timescale 1ns / 1ps

//  channel   | signals                                     | direction
//  ----------+---------------------------------------------+----------
//  in        | in_valid, in_ready, sample                  | request in
//  out       | out_valid, out_ready, filter_ran,           | request out
//            | rising_crossing, filter_out                 |
//  apb       | psel, penable, pwrite, paddr, pwdata,       | register access
//            | prdata, pready                              |
//
// a skipped sample goes from accept through ST_DONE to the output register; a
// filtered one is loaded into the bit-serial mac: 21 taps times 18 coefficient
// bits, one coefficient bit against one tap per cycle, then round and hand-off
// one request is in flight at a time; a finished result waits in the output
// register while the next request is accepted
// reset clears the delay line, the sample count, the previous filtered value
// and sets the decimation factor to 10; a stalled output holds its result

module decimated_fir_zero_cross_detector_core import dfzc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result requests
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          filter_ran,
	output logic                          rising_crossing,
	output logic signed [SAMPLE_BITS-1:0] filter_out,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	top_state_t state_q, state_d;

	logic [DECIM_W-1:0] decim;
	logic [DECIM_W-1:0] limit;
	logic [CNT_W-1:0]   cnt_q;
	logic               hit;
	logic               accept;
	logic               slot_free;
	logic               load_out;

	mac_req_t mac_req;
	mac_rsp_t mac_rsp;

	// previous filtered value and the result waiting for the output register
	logic signed [SAMPLE_BITS-1:0] last_q;
	logic                          pend_ran_q;
	logic                          pend_rise_q;
	logic signed [SAMPLE_BITS-1:0] pend_val_q;

	// output register
	logic                          out_valid_q;
	logic                          filter_ran_q;
	logic                          rising_crossing_q;
	logic signed [SAMPLE_BITS-1:0] filter_out_q;

	dfzc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.decim   (decim)
	);

	dfzc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	// zero acts as one, anything above the maximum is clamped
	always_comb begin
		if (decim == '0) begin
			limit = DECIM_W'(1);
		end else if (decim > DECIM_W'(MAX_DECIM)) begin
			limit = DECIM_W'(MAX_DECIM);
		end else begin
			limit = decim;
		end
		hit = ((DECIM_W'(cnt_q) + DECIM_W'(1)) >= limit);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		mac_req.start  = 1'b0;
		mac_req.sample = sample;
		load_out       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (hit) begin
						// kept sample goes into the filter
						mac_req.start = 1'b1;
						state_d       = ST_FILT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FILT: begin
				if (mac_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sample count and previous filtered value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else begin
			if (accept) begin
				cnt_q <= hit ? '0 : (cnt_q + CNT_W'(1));
			end
			if (mac_rsp.done) begin
				last_q <= mac_rsp.y;
			end
		end
	end

	// pending result: a skipped sample repeats the previous value
	always_ff @(posedge clk) begin
		if (accept && !hit) begin
			pend_ran_q  <= 1'b0;
			pend_rise_q <= 1'b0;
			pend_val_q  <= last_q;
		end else if (mac_rsp.done) begin
			pend_ran_q  <= 1'b1;
			// negative before, strictly positive now
			pend_rise_q <= last_q[SAMPLE_BITS-1] && !mac_rsp.y[SAMPLE_BITS-1]
				&& (mac_rsp.y != '0);
			pend_val_q  <= mac_rsp.y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filter_ran_q      <= pend_ran_q;
			rising_crossing_q <= pend_rise_q;
			filter_out_q      <= pend_val_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign filter_ran      = filter_ran_q;
	assign rising_crossing = rising_crossing_q;
	assign filter_out      = filter_out_q;

endmodule

// File: rtl/dfzc_checker.sv
// port-level checks for the detector core, bound to the top level
`timescale 1ns / 1ps

module dfzc_checker import dfzc_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          filter_ran,
	input logic                          rising_crossing,
	input logic signed [SAMPLE_BITS-1:0] filter_out
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filter_out)
			&& $stable(filter_ran) && $stable(rising_crossing))
		else $error("stalled result changed");

	// a crossing only comes with a filter run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rising_crossing |-> filter_ran)
		else $error("crossing without filter run");

	// a crossing ends on a strictly positive value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rising_crossing |->
			!filter_out[SAMPLE_BITS-1] && (filter_out != '0))
		else $error("crossing on a non-positive value");

	// one request in flight: no accept in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind decimated_fir_zero_cross_detector_core dfzc_checker u_dfzc_checker (.*);
